// ----- rtl/rlb_pkg.sv -----
// ----------------------------------------------------------------------------
// rlb_pkg
// Shared types, widths and constants of the reciprocal lattice basis unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rlb_pkg;

   localparam int FRAC_BITS = 16;
   localparam int M_W       = 32;
   localparam int R_W       = 32;
   localparam int DIM_W     = 3;
   localparam int NSLOT     = 10;
   localparam int NDIAG     = 4;

   localparam logic [DIM_W-1:0] DIM_2 = 3'd2;
   localparam logic [DIM_W-1:0] DIM_3 = 3'd3;
   localparam logic [DIM_W-1:0] DIM_4 = 3'd4;

   localparam int DIAG_SLOT [NDIAG] = '{0, 4, 8, 9};

   // 2*pi with PI2_FRAC fraction bits
   localparam int            PI2_FRAC  = 60;
   localparam int            K_W       = 63;
   localparam logic [K_W-1:0] PI2_CONST = 63'h6487ED5110B4611A;

   localparam int X_W    = 64;
   localparam int AX_W   = 64;
   localparam int Y_W    = 98;
   localparam int AY_W   = 97;
   localparam int P_W    = K_W + AX_W;
   localparam int NUM_SH = 2 * FRAC_BITS + 1;
   localparam int DEN_SH = PI2_FRAC;
   localparam int DROP   = PI2_FRAC + 1;
   localparam int T_W    = ((P_W + NUM_SH) > (AY_W + DEN_SH) ?
                            (P_W + NUM_SH) : (AY_W + DEN_SH)) + 1;
   localparam int A_W    = T_W - DROP;
   localparam int Q_W    = 33;
   localparam int D_W    = AY_W + Q_W - 1;
   localparam int SAT_W  = AY_W + Q_W;
   localparam int CMP_W  = (A_W > SAT_W) ? A_W : SAT_W;
   localparam int STEP_W = $clog2(Q_W);

   localparam logic [R_W-1:0] R_MAX = 32'h7FFF_FFFF;
   localparam logic [R_W-1:0] R_MIN = 32'h8000_0000;

   localparam int QDEPTH    = 8;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);
   localparam int FE_STAGES = 4;
   localparam int CRED_W    = $clog2(QDEPTH + FE_STAGES + 1);

   typedef struct packed {
      logic [DIM_W-1:0]        dim;
      logic [8:0][M_W-1:0]     m;
      logic [M_W-1:0]          m33;
   } box_type;

   typedef struct packed {
      logic                     singular;
      logic                     dim4;
      logic [NSLOT-1:0]         live;
      logic [NSLOT-1:0][X_W-1:0] x;
      logic [Y_W-1:0]           y;
      logic [NDIAG-1:0][M_W-1:0] diag;
   } job_type;

   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] count;
   } q_status_type;

   typedef struct packed {
      logic       load;
      logic       mul;
      logic [1:0] mul_sel;
      logic       form;
      logic       check;
      logic       div;
   } lane_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FORM,
      ST_CHECK,
      ST_DIV,
      ST_DONE
   } back_state_type;

   function automatic logic [1:0] diag_of(input int slot);
      logic [1:0] idx;
      idx = '0;
      for (int k = 0; k < NDIAG; k++) begin
         if (DIAG_SLOT[k] == slot) idx = 2'(k);
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/rlb_front.sv -----
// ----------------------------------------------------------------------------
// rlb_front
// Accepts boxes, forms cross products and determinant, classifies the job.
// ----------------------------------------------------------------------------
`default_nettype none

module rlb_front import rlb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  box_type      box,
   input  q_status_type q_status,
   output logic         push,
   output job_type      push_job
);

   logic    v1_ff, v2_ff, v3_ff, v4_ff;
   box_type b1_ff, b2_ff, b3_ff, b4_ff;
   logic signed [63:0] p_ff  [3][3][2];
   logic signed [63:0] c_ff  [3][3];
   logic signed [63:0] c4_ff [3][3];
   logic signed [64:0] lo_ff [3];
   logic signed [63:0] hi_ff [3];
   logic [CRED_W-1:0]  used;
   logic               accept;

   assign used   = CRED_W'(q_status.count) + CRED_W'(v1_ff) + CRED_W'(v2_ff)
                 + CRED_W'(v3_ff) + CRED_W'(v4_ff);
   assign busy   = used >= CRED_W'(QDEPTH);
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) b1_ff <= box;
      b2_ff <= b1_ff;
      b3_ff <= b2_ff;
      b4_ff <= b3_ff;
   end

   for (genvar i = 0; i < 3; i++) begin : g_row
      localparam int P = (i + 1) % 3;
      localparam int S = (i + 2) % 3;
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int A = (j + 1) % 3;
         localparam int B = (j + 2) % 3;
         always_ff @(posedge clock) begin
            p_ff[i][j][0] <= $signed(b1_ff.m[P*3+A]) * $signed(b1_ff.m[S*3+B]);
            p_ff[i][j][1] <= $signed(b1_ff.m[P*3+B]) * $signed(b1_ff.m[S*3+A]);
            c_ff[i][j]    <= p_ff[i][j][0] - p_ff[i][j][1];
            c4_ff[i][j]   <= c_ff[i][j];
         end
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_triple
      always_ff @(posedge clock) begin
         lo_ff[j] <= $signed(b3_ff.m[j]) * $signed({1'b0, c_ff[0][j][31:0]});
         hi_ff[j] <= $signed(b3_ff.m[j]) * $signed(c_ff[0][j][63:32]);
      end
   end

   logic signed [Y_W-1:0] y3;
   logic signed [63:0]    det;

   always_comb begin
      y3 = '0;
      for (int j = 0; j < 3; j++) begin
         y3 = y3 + (Y_W'(hi_ff[j]) <<< 32) + Y_W'(lo_ff[j]);
      end
   end

   assign det = c4_ff[2][2];

   always_comb begin
      push_job          = '0;
      push_job.diag[0]  = b4_ff.m[0];
      push_job.diag[1]  = b4_ff.m[4];
      push_job.diag[2]  = b4_ff.m[8];
      push_job.diag[3]  = b4_ff.m33;
      case (b4_ff.dim)
         DIM_2: begin
            push_job.y = Y_W'(det);
            if (det == '0) begin
               push_job.singular = 1'b1;
            end else begin
               push_job.live[0] = 1'b1;
               push_job.live[1] = 1'b1;
               push_job.live[3] = 1'b1;
               push_job.live[4] = 1'b1;
               push_job.x[0]    = X_W'($signed(b4_ff.m[4]));
               push_job.x[1]    = -X_W'($signed(b4_ff.m[3]));
               push_job.x[3]    = -X_W'($signed(b4_ff.m[1]));
               push_job.x[4]    = X_W'($signed(b4_ff.m[0]));
            end
         end
         DIM_3: begin
            push_job.y = y3;
            if (y3 == '0) begin
               push_job.singular = 1'b1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  for (int j = 0; j < 3; j++) begin
                     push_job.live[i*3+j] = 1'b1;
                     push_job.x[i*3+j]    = c4_ff[i][j];
                  end
               end
            end
         end
         DIM_4: begin
            push_job.dim4 = 1'b1;
            for (int k = 0; k < NDIAG; k++) begin
               if (push_job.diag[k] == '0) begin
                  push_job.singular = 1'b1;
               end else begin
                  push_job.live[DIAG_SLOT[k]] = 1'b1;
                  push_job.x[DIAG_SLOT[k]]    = X_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign push = v4_ff;

endmodule

`default_nettype wire

// ----- rtl/rlb_queue.sv -----
// ----------------------------------------------------------------------------
// rlb_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rlb_queue import rlb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head,
   output q_status_type status
);

   job_type             mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_job;
   end

   assign head         = mem[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCNT_W'(QDEPTH)))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue pop while empty");
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ----- rtl/rlb_lane.sv -----
// ----------------------------------------------------------------------------
// rlb_lane
// One output entry: scaled numerator product and radix-2 division.
// ----------------------------------------------------------------------------
`default_nettype none

module rlb_lane import rlb_pkg::*; (
   input  logic                  clock,
   input  lane_ctrl_type         ctrl,
   input  logic                  live,
   input  logic signed [X_W-1:0] x,
   input  logic signed [Y_W-1:0] y,
   output logic [R_W-1:0]        r
);

   logic             live_ff, live_in;
   logic             neg_ff, neg_in;
   logic             sat_ff, sat_in;
   logic [AX_W-1:0]  ax_ff, ax_in;
   logic [AY_W-1:0]  ay_ff, ay_in;
   logic [P_W-1:0]   acc_ff, acc_in;
   logic [A_W-1:0]   a_ff, a_in;
   logic [D_W-1:0]   d_ff, d_in;
   logic [Q_W-1:0]   q_ff, q_in;

   logic [31:0]      mul_a, mul_b;
   logic [63:0]      pp;
   logic [P_W-1:0]   pp_sh;
   logic [T_W-1:0]   t;
   logic             ge;
   logic [CMP_W-1:0] diff;
   logic             big;

   assign mul_a = ctrl.mul_sel[0] ? ax_ff[63:32] : ax_ff[31:0];
   assign mul_b = ctrl.mul_sel[1] ? {1'b0, PI2_CONST[K_W-1:32]} : PI2_CONST[31:0];
   assign pp    = mul_a * mul_b;

   always_comb begin
      unique case (ctrl.mul_sel)
         2'b00:   pp_sh = P_W'(pp);
         2'b11:   pp_sh = P_W'(pp) << 64;
         default: pp_sh = P_W'(pp) << 32;
      endcase
   end

   assign t    = (T_W'(acc_ff) << NUM_SH) + (T_W'(ay_ff) << DEN_SH);
   assign ge   = CMP_W'(a_ff) >= CMP_W'(d_ff);
   assign diff = CMP_W'(a_ff) - CMP_W'(d_ff);

   always_comb begin
      live_in = live_ff;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      priority if (ctrl.load) begin
         live_in = live;
         neg_in  = (x != '0) && (x[X_W-1] ^ y[Y_W-1]);
         ax_in   = x[X_W-1] ? AX_W'(-x) : AX_W'(x);
         ay_in   = y[Y_W-1] ? AY_W'(-y) : AY_W'(y);
         acc_in  = '0;
      end else if (ctrl.mul) begin
         acc_in = acc_ff + pp_sh;
      end else if (ctrl.form) begin
         a_in = t[T_W-1:DROP];
      end else if (ctrl.check) begin
         sat_in = CMP_W'(a_ff) >= (CMP_W'(ay_ff) << Q_W);
         d_in   = D_W'(ay_ff) << (Q_W - 1);
         q_in   = '0;
      end else if (ctrl.div) begin
         a_in = ge ? A_W'(diff) : a_ff;
         q_in = {q_ff[Q_W-2:0], ge};
         d_in = d_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      live_ff <= live_in;
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      d_ff    <= d_in;
      q_ff    <= q_in;
   end

   assign big = sat_ff | q_ff[Q_W-1] | q_ff[R_W-1];

   always_comb begin
      priority if (!live_ff) begin
         r = '0;
      end else if (neg_ff) begin
         r = big ? R_MIN : -q_ff[R_W-1:0];
      end else begin
         r = big ? R_MAX : q_ff[R_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rlb_back.sv -----
// ----------------------------------------------------------------------------
// rlb_back
// Sequences the lanes through multiply and divide, registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rlb_back import rlb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  job_type                head,
   input  q_status_type           q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic [NSLOT-1:0][R_W-1:0] rsp_r,
   output logic                   rsp_singular
);

   back_state_type           state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     singular_ff, singular_in;
   logic                     rsp_valid_ff;
   logic [NSLOT-1:0][R_W-1:0] rsp_r_ff;
   logic                     rsp_singular_ff;
   logic                     capture;
   lane_ctrl_type            ctrl;
   logic [NSLOT-1:0][R_W-1:0] lane_r;

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      singular_in = singular_ff;
      ctrl        = '0;
      pop         = 1'b0;
      capture     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop         = 1'b1;
               ctrl.load   = 1'b1;
               singular_in = head.singular;
               step_in     = '0;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            ctrl.mul     = 1'b1;
            ctrl.mul_sel = step_ff[1:0];
            if (step_ff == STEP_W'(3)) begin
               step_in  = '0;
               state_in = ST_FORM;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FORM: begin
            ctrl.form = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            ctrl.check = 1'b1;
            step_in    = STEP_W'(Q_W - 1);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            ctrl.div = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DONE: begin
            capture = 1'b1;
            if (!q_status.empty) begin
               pop         = 1'b1;
               ctrl.load   = 1'b1;
               singular_in = head.singular;
               step_in     = '0;
               state_in    = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= capture;
      end
   end

   always_ff @(posedge clock) begin
      singular_ff <= singular_in;
      if (capture) begin
         rsp_r_ff        <= lane_r;
         rsp_singular_ff <= singular_ff;
      end
   end

   for (genvar j = 0; j < NSLOT; j++) begin : g_lane
      logic signed [Y_W-1:0] lane_y;
      assign lane_y = head.dim4 ? Y_W'($signed(head.diag[diag_of(j)])) : head.y;
      rlb_lane u_lane (
         .clock (clock),
         .ctrl  (ctrl),
         .live  (head.live[j]),
         .x     (head.x[j]),
         .y     (lane_y),
         .r     (lane_r[j])
      );
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_r        = rsp_r_ff;
   assign rsp_singular = rsp_singular_ff;

`ifndef NO_ASSERTIONS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");
   a_pop_state: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE || state_ff == ST_DONE))
      else $error("job taken while lanes busy");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == '0) |=> (state_ff == ST_DONE))
      else $error("division did not finish");
`endif

endmodule

`default_nettype wire

// ----- rtl/reciprocal_lattice_basis_unit.sv -----
// ----------------------------------------------------------------------------
// reciprocal_lattice_basis_unit
// Reciprocal basis (2*pi times inverse transpose) of a 2D, 3D or 4D-diagonal
// box in signed fixed point, rounded to nearest and saturated.
// ----------------------------------------------------------------------------
// A box is taken at each clock edge with start high and busy low. The front
// pipeline forms cross products and determinant and places the job in an
// eight-entry queue; busy rises once the boxes held in that queue and in the
// front pipeline together reach eight. Ten lanes then work on the entries at
// once: they accumulate four 32x32 partial products, form and check the
// dividend, run a radix-2 divide for a 33-bit quotient and, in a last state,
// register the result while the next job loads; a job is taken from the
// queue only in that state or when idle. Each result is shown for exactly one
// cycle with rsp_valid high and must be taken then.
// ----------------------------------------------------------------------------
`default_nettype none

module reciprocal_lattice_basis_unit import rlb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DIM_W-1:0]      req_dimension,
   input  logic signed [M_W-1:0] req_m00,
   input  logic signed [M_W-1:0] req_m01,
   input  logic signed [M_W-1:0] req_m02,
   input  logic signed [M_W-1:0] req_m10,
   input  logic signed [M_W-1:0] req_m11,
   input  logic signed [M_W-1:0] req_m12,
   input  logic signed [M_W-1:0] req_m20,
   input  logic signed [M_W-1:0] req_m21,
   input  logic signed [M_W-1:0] req_m22,
   input  logic signed [M_W-1:0] req_m33,
   output logic                  rsp_valid,
   output logic signed [R_W-1:0] rsp_r00,
   output logic signed [R_W-1:0] rsp_r01,
   output logic signed [R_W-1:0] rsp_r02,
   output logic signed [R_W-1:0] rsp_r10,
   output logic signed [R_W-1:0] rsp_r11,
   output logic signed [R_W-1:0] rsp_r12,
   output logic signed [R_W-1:0] rsp_r20,
   output logic signed [R_W-1:0] rsp_r21,
   output logic signed [R_W-1:0] rsp_r22,
   output logic signed [R_W-1:0] rsp_r33,
   output logic                  rsp_singular
);

   box_type                   box;
   q_status_type              q_status;
   logic                      push;
   logic                      pop;
   job_type                   push_job;
   job_type                   head;
   logic [NSLOT-1:0][R_W-1:0] rsp_r;

   assign box.dim  = req_dimension;
   assign box.m[0] = req_m00;
   assign box.m[1] = req_m01;
   assign box.m[2] = req_m02;
   assign box.m[3] = req_m10;
   assign box.m[4] = req_m11;
   assign box.m[5] = req_m12;
   assign box.m[6] = req_m20;
   assign box.m[7] = req_m21;
   assign box.m[8] = req_m22;
   assign box.m33  = req_m33;

   rlb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .box      (box),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   rlb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   rlb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_r        (rsp_r),
      .rsp_singular (rsp_singular)
   );

   assign rsp_r00 = rsp_r[0];
   assign rsp_r01 = rsp_r[1];
   assign rsp_r02 = rsp_r[2];
   assign rsp_r10 = rsp_r[3];
   assign rsp_r11 = rsp_r[4];
   assign rsp_r12 = rsp_r[5];
   assign rsp_r20 = rsp_r[6];
   assign rsp_r21 = rsp_r[7];
   assign rsp_r22 = rsp_r[8];
   assign rsp_r33 = rsp_r[9];

endmodule

`default_nettype wire
